// File: rtl/u8sd_pkg.sv
package u8sd_pkg;

   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int LEN_W      = 3;
   localparam int STATUS_W   = 3;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [STATUS_W-1:0] {
      ST_PENDING  = 3'd0,
      ST_DONE     = 3'd1,
      ST_BAD_LEAD = 3'd2,
      ST_BAD_CONT = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   localparam logic [LEN_W-1:0] LEN_ZERO = 3'd0;
   localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

   localparam logic [CP_W-1:0] CP_MIN2 = 21'h00080;
   localparam logic [CP_W-1:0] CP_MAX2 = 21'h007FF;
   localparam logic [CP_W-1:0] CP_MIN3 = 21'h00800;
   localparam logic [CP_W-1:0] CP_MAX3 = 21'h0FFFF;
   localparam logic [CP_W-1:0] CP_MIN4 = 21'h10000;
   localparam logic [CP_W-1:0] CP_MAX4 = 21'h10FFFF;

endpackage

// File: rtl/utf8_sequence_decoder_unit.sv
// Byte-serial UTF-8 decoder. Each accepted byte on req_ gives exactly one word on rsp_,
// in order: status in rsp_tuser (pending, code point done, bad lead, bad continuation,
// overlong or out of range), and on a finished code point the scalar value and the
// sequence length in rsp_tdata (both zero for any other status). A failing sequence is
// dropped and the offending byte consumed; surrogates are passed through. The block
// takes one byte every cycle while rsp_tready is held high; a byte is registered on input,
// decoded against the open sequence state and registered on output, where its word is
// presented on rsp_. Reset closes any open sequence.
module utf8_sequence_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [u8sd_pkg::BYTE_W-1:0]         req_tdata,  // [7:0] in_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [u8sd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [20:0] code_point, [23:21] seq_length
   output logic [u8sd_pkg::STATUS_W-1:0]       rsp_tuser   // [2:0] status
);
   import u8sd_pkg::*;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // open sequence state
   logic              pending_ff, pending_in;
   logic [LEN_W-1:0]  full_length_ff, full_length_in;
   logic [LEN_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [CP_W-1:0]   acc_ff, acc_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   status_type        status_ff, status_in;
   logic [CP_W-1:0]   cp_ff, cp_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              out_ready;
   logic              advance;
   logic [CP_W-1:0]   acc_shift;
   logic [LEN_W-1:0]  seen_next;
   logic              in_range;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   assign acc_shift = {acc_ff[CP_W-7:0], in_byte_ff[5:0]};
   assign seen_next = bytes_seen_ff + LEN_ONE;

   always_comb begin
      case (full_length_ff)
         LEN_TWO:   in_range = (acc_shift >= CP_MIN2) && (acc_shift <= CP_MAX2);
         LEN_THREE: in_range = (acc_shift >= CP_MIN3) && (acc_shift <= CP_MAX3);
         default:   in_range = (acc_shift >= CP_MIN4) && (acc_shift <= CP_MAX4);
      endcase
   end

   // decode of one byte against the open sequence
   always_comb begin
      pending_in     = pending_ff;
      full_length_in = full_length_ff;
      bytes_seen_in  = bytes_seen_ff;
      acc_in         = acc_ff;
      status_in      = ST_PENDING;
      cp_in          = '0;
      len_in         = LEN_ZERO;
      if (!pending_ff) begin
         if (!in_byte_ff[7]) begin
            status_in = ST_DONE;
            cp_in     = CP_W'(in_byte_ff);
            len_in    = LEN_ONE;
         end else if (in_byte_ff <= 8'hC1 || in_byte_ff == 8'hF5 || in_byte_ff >= 8'hF8) begin
            status_in = ST_BAD_LEAD;
         end else begin
            pending_in    = 1'b1;
            bytes_seen_in = LEN_ONE;
            if (in_byte_ff < 8'hE0) begin
               full_length_in = LEN_TWO;
               acc_in         = CP_W'(in_byte_ff[4:0]);
            end else if (in_byte_ff < 8'hF0) begin
               full_length_in = LEN_THREE;
               acc_in         = CP_W'(in_byte_ff[3:0]);
            end else begin
               full_length_in = LEN_FOUR;
               acc_in         = CP_W'(in_byte_ff[2:0]);
            end
         end
      end else if (in_byte_ff[7:6] != 2'b10) begin
         status_in      = ST_BAD_CONT;
         pending_in     = 1'b0;
         full_length_in = LEN_ZERO;
         bytes_seen_in  = LEN_ZERO;
         acc_in         = '0;
      end else if (seen_next >= full_length_ff) begin
         pending_in     = 1'b0;
         full_length_in = LEN_ZERO;
         bytes_seen_in  = LEN_ZERO;
         acc_in         = '0;
         if (in_range) begin
            status_in = ST_DONE;
            cp_in     = acc_shift;
            len_in    = full_length_ff;
         end else begin
            status_in = ST_RANGE;
         end
      end else begin
         bytes_seen_in = seen_next;
         acc_in        = acc_shift;
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign in_byte_in   = (req_tvalid && req_tready) ? req_tdata : in_byte_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pending_ff     <= 1'b0;
         full_length_ff <= LEN_ZERO;
         bytes_seen_ff  <= LEN_ZERO;
         acc_ff         <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pending_ff     <= pending_in;
            full_length_ff <= full_length_in;
            bytes_seen_ff  <= bytes_seen_in;
            acc_ff         <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance) begin
         status_ff <= status_in;
         cp_ff     <= cp_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {len_ff, cp_ff};
   assign rsp_tuser  = status_ff;

endmodule
